>>> rtl/jnzq_pkg.sv
// jnzq_pkg: shared widths, types, register indexes and zone codes for the
// joystick nine-zone quantizer; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package jnzq_pkg;

	localparam int POSITION_WIDTH = 8;

	// signed working width: spans reach about -(2^W + 2*dead)
	localparam int CALC_WIDTH  = POSITION_WIDTH + 4;
	localparam int MAG_WIDTH   = POSITION_WIDTH + 3;

	// divide by three as multiply by reciprocal; exact for magnitudes below 2^MAG_WIDTH
	localparam int DIV_SHIFT   = MAG_WIDTH + 1;
	localparam int RECIP_WIDTH = DIV_SHIFT;
	localparam int PROD_WIDTH  = MAG_WIDTH + RECIP_WIDTH;

	localparam int CFG_INDEX_WIDTH = 3;
	localparam int BITS_WIDTH      = 4;
	localparam int CFG_DATA_WIDTH  = (POSITION_WIDTH > BITS_WIDTH) ? POSITION_WIDTH : BITS_WIDTH;

	typedef logic [POSITION_WIDTH-1:0]    position_t;
	typedef logic [BITS_WIDTH-1:0]        bits_t;
	typedef logic signed [CALC_WIDTH-1:0] calc_t;
	typedef logic [MAG_WIDTH-1:0]         mag_t;
	typedef logic [RECIP_WIDTH-1:0]       recip_t;
	typedef logic [PROD_WIDTH-1:0]        prod_t;
	typedef logic signed [3:0]            zone_t;
	typedef logic [CFG_INDEX_WIDTH-1:0]   cfg_index_t;
	typedef logic [CFG_DATA_WIDTH-1:0]    cfg_data_t;
	typedef logic [2:0]                   cls_t;

	localparam recip_t RECIP = recip_t'((2 ** DIV_SHIFT + 2) / 3);

	// register indexes
	localparam cfg_index_t REG_X_MINIMUM   = 3'd0;
	localparam cfg_index_t REG_X_CENTRE    = 3'd1;
	localparam cfg_index_t REG_X_MAXIMUM   = 3'd2;
	localparam cfg_index_t REG_Y_MINIMUM   = 3'd3;
	localparam cfg_index_t REG_Y_CENTRE    = 3'd4;
	localparam cfg_index_t REG_Y_MAXIMUM   = 3'd5;
	localparam cfg_index_t REG_SAMPLE_BITS = 3'd6;

	localparam position_t POS_MIN_RESET    = '0;
	localparam position_t POS_CENTRE_RESET = position_t'(1 << (POSITION_WIDTH - 1));
	localparam position_t POS_MAX_RESET    = '1;
	localparam bits_t     BITS_RESET       = bits_t'(8);

	// dead zone selection
	localparam bits_t     BITS_FINE_LIMIT = bits_t'(7);
	localparam position_t DEAD_NARROW     = position_t'(1);
	localparam position_t DEAD_WIDE       = position_t'(8);

	localparam calc_t CALC_ONE = calc_t'(1);
	localparam mag_t  REST_TWO = mag_t'(2);

	// coarse classes decided in the first stage
	localparam cls_t CLS_CENTRE = 3'd0;
	localparam cls_t CLS_LOW    = 3'd1;
	localparam cls_t CLS_HIGH   = 3'd2;
	localparam cls_t CLS_LEFT   = 3'd3;
	localparam cls_t CLS_RIGHT  = 3'd4;

	localparam zone_t ZONE_NEG_4 = -4'sd4;
	localparam zone_t ZONE_NEG_3 = -4'sd3;
	localparam zone_t ZONE_NEG_2 = -4'sd2;
	localparam zone_t ZONE_NEG_1 = -4'sd1;
	localparam zone_t ZONE_0     = 4'sd0;
	localparam zone_t ZONE_POS_1 = 4'sd1;
	localparam zone_t ZONE_POS_2 = 4'sd2;
	localparam zone_t ZONE_POS_3 = 4'sd3;
	localparam zone_t ZONE_POS_4 = 4'sd4;

	typedef struct packed {
		position_t minimum;
		position_t centre;
		position_t maximum;
		position_t dead;
	} axis_cfg_t;

	typedef struct packed {
		axis_cfg_t x;
		axis_cfg_t y;
	} cfg_t;

	// load strobes for the four pipeline stages
	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic load_s3;
		logic load_s4;
	} stage_ctl_t;

	function automatic calc_t to_calc(position_t v);
		return calc_t'({1'b0, v});
	endfunction

endpackage

`default_nettype wire

>>> rtl/jnzq_if.sv
// jnzq_if: valid/ready channels for joystick samples and zone results
// depends on jnzq_pkg
`timescale 1ns / 1ps
`default_nettype none

interface jnzq_sample_if import jnzq_pkg::*; ();
	logic      valid;
	logic      ready;
	position_t x_position;
	position_t y_position;

	modport source (output valid, output x_position, output y_position, input ready);
	modport sink   (input valid, input x_position, input y_position, output ready);
endinterface

interface jnzq_zone_if import jnzq_pkg::*; ();
	logic  valid;
	logic  ready;
	zone_t x_zone;
	zone_t y_zone;

	modport source (output valid, output x_zone, output y_zone, input ready);
	modport sink   (input valid, input x_zone, input y_zone, output ready);
endinterface

`default_nettype wire

>>> rtl/jnzq_regs.sv
// jnzq_regs: calibration and resolution registers with dead zone decode
// depends on jnzq_pkg
`timescale 1ns / 1ps
`default_nettype none

module jnzq_regs import jnzq_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire cfg_index_t cfg_index,
	input  wire cfg_data_t  cfg_data,
	output cfg_t            cfg
);

	position_t x_min_q, x_mid_q, x_max_q;
	position_t y_min_q, y_mid_q, y_max_q;
	bits_t     bits_q;
	position_t dead;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= POS_MIN_RESET;
			x_mid_q <= POS_CENTRE_RESET;
			x_max_q <= POS_MAX_RESET;
			y_min_q <= POS_MIN_RESET;
			y_mid_q <= POS_CENTRE_RESET;
			y_max_q <= POS_MAX_RESET;
			bits_q  <= BITS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_MINIMUM:   x_min_q <= cfg_data[POSITION_WIDTH-1:0];
				REG_X_CENTRE:    x_mid_q <= cfg_data[POSITION_WIDTH-1:0];
				REG_X_MAXIMUM:   x_max_q <= cfg_data[POSITION_WIDTH-1:0];
				REG_Y_MINIMUM:   y_min_q <= cfg_data[POSITION_WIDTH-1:0];
				REG_Y_CENTRE:    y_mid_q <= cfg_data[POSITION_WIDTH-1:0];
				REG_Y_MAXIMUM:   y_max_q <= cfg_data[POSITION_WIDTH-1:0];
				REG_SAMPLE_BITS: bits_q  <= cfg_data[BITS_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// coarse resolutions get the narrow dead zone
	assign dead = (bits_q < BITS_FINE_LIMIT) ? DEAD_NARROW : DEAD_WIDE;

	assign cfg.x = '{minimum: x_min_q, centre: x_mid_q, maximum: x_max_q, dead: dead};
	assign cfg.y = '{minimum: y_min_q, centre: y_mid_q, maximum: y_max_q, dead: dead};

endmodule

`default_nettype wire

>>> rtl/jnzq_axis.sv
// jnzq_axis: four-stage zone datapath for one axis (classify, divide, third, zone)
// depends on jnzq_pkg; stage loads come from the top-level pipeline control
`timescale 1ns / 1ps
`default_nettype none

module jnzq_axis import jnzq_pkg::*; (
	input  wire logic       clk,
	input  wire stage_ctl_t ctl,
	input  wire axis_cfg_t  cfg,
	input  wire position_t  position,
	output zone_t           zone_s4
);

	calc_t mn, mid, mx, dv;
	calc_t pv_in;
	logic  centre, low, high, left;
	cls_t  cls_in;
	calc_t span_in;

	position_t pos_s1, pos_s2, pos_s3;
	cls_t      cls_s1, cls_s2, cls_s3;
	calc_t     span_s1;
	mag_t      mag_s2, q_s2;
	logic      neg_s2;
	calc_t     third_s3;
	logic      ext_s3;

	mag_t  mag_in;
	prod_t prod;
	mag_t  rest;
	calc_t q_calc;
	calc_t pv, ev, hi_left, lo_right;
	zone_t zone_next;

	function automatic calc_t to_calc_mag(mag_t v);
		return calc_t'({1'b0, v});
	endfunction

	assign mn  = to_calc(cfg.minimum);
	assign mid = to_calc(cfg.centre);
	assign mx  = to_calc(cfg.maximum);
	assign dv  = to_calc(cfg.dead);

	// stage 1: priority classes and inner span of the chosen side
	always_comb begin
		pv_in  = to_calc(position);
		centre = (pv_in >= mid - dv) && (pv_in <= mid + dv);
		low    = (pv_in <= mn + dv);
		high   = (pv_in >= mx - dv);
		left   = (pv_in < mid - dv);
		priority if (centre) cls_in = CLS_CENTRE;
		else if (low)        cls_in = CLS_LOW;
		else if (high)       cls_in = CLS_HIGH;
		else if (left)       cls_in = CLS_LEFT;
		else                 cls_in = CLS_RIGHT;
		if (left) span_in = mid - mn - dv - dv - CALC_ONE;
		else      span_in = mx - mid - dv - dv - CALC_ONE;
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			pos_s1  <= position;
			cls_s1  <= cls_in;
			span_s1 <= span_in;
		end
	end

	// stage 2: magnitude times reciprocal of three
	assign mag_in = span_s1[CALC_WIDTH-1] ? mag_t'(-span_s1) : mag_t'(span_s1);
	assign prod   = prod_t'(mag_in) * prod_t'(RECIP);

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			pos_s2 <= pos_s1;
			cls_s2 <= cls_s1;
			neg_s2 <= span_s1[CALC_WIDTH-1];
			mag_s2 <= mag_in;
			q_s2   <= prod[DIV_SHIFT +: MAG_WIDTH];
		end
	end

	// stage 3: signed third, truncated toward zero, and the remainder-two widening
	assign rest   = mag_s2 - q_s2 - (q_s2 << 1);
	assign q_calc = to_calc_mag(q_s2);

	always_ff @(posedge clk) begin
		if (ctl.load_s3) begin
			pos_s3   <= pos_s2;
			cls_s3   <= cls_s2;
			third_s3 <= neg_s2 ? -q_calc : q_calc;
			ext_s3   <= !neg_s2 && (rest == REST_TWO);
		end
	end

	// stage 4: inner zone thresholds
	always_comb begin
		pv       = to_calc(pos_s3);
		ev       = calc_t'(ext_s3);
		hi_left  = mid - dv - CALC_ONE;
		lo_right = mid + dv + CALC_ONE;
		unique case (cls_s3)
			CLS_CENTRE: zone_next = ZONE_0;
			CLS_LOW:    zone_next = ZONE_NEG_4;
			CLS_HIGH:   zone_next = ZONE_POS_4;
			CLS_LEFT: begin
				if (pv <= hi_left - third_s3 - third_s3 - ev)   zone_next = ZONE_NEG_3;
				else if (pv >= hi_left - third_s3 + CALC_ONE)   zone_next = ZONE_NEG_1;
				else                                            zone_next = ZONE_NEG_2;
			end
			CLS_RIGHT: begin
				if (pv <= lo_right + third_s3 - CALC_ONE)           zone_next = ZONE_POS_1;
				else if (pv >= lo_right + third_s3 + third_s3 + ev) zone_next = ZONE_POS_3;
				else                                                zone_next = ZONE_POS_2;
			end
			default: zone_next = ZONE_0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s4) begin
			zone_s4 <= zone_next;
		end
	end

endmodule

`default_nettype wire

>>> rtl/joystick_nine_zone_quantizer_top.sv
// joystick_nine_zone_quantizer_top: top level, pipeline valid/ready control,
// register file and two axis datapaths; depends on jnzq_pkg, jnzq_if, jnzq_regs, jnzq_axis
`timescale 1ns / 1ps
`default_nettype none

// Sorts each joystick sample into a nine-level zone per axis, -4 to +4, using the
// calibration registers (minimum, centre, maximum per axis) and a dead zone of 1 when
// sample_bits is below 7, else 8. The y zone is negated so readings below the y centre
// come out positive. One request yields exactly one result. The datapath is a four-stage
// pipeline: a new request is taken every cycle while the result side keeps ready high,
// and each result moves through the stages in order. The depth is set by the chain
// classify, multiply-by-reciprocal divide by three, remainder fix-up, threshold compare.
// Each stage holds its own valid bit and only stalls when everything ahead of it is full,
// so bubbles are squeezed out and a waiting result blocks new requests only once all
// four stages hold one.
// Registers are written through cfg_we/cfg_index/cfg_data (index 0..6 in the order
// x_minimum, x_centre, x_maximum, y_minimum, y_centre, y_maximum, sample_bits; index 7
// is ignored); write them only while no request is in flight. There is no read-back.

module joystick_nine_zone_quantizer_top import jnzq_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	jnzq_sample_if.sink     sample,
	jnzq_zone_if.source     zone,
	input  wire logic       cfg_we,
	input  wire cfg_index_t cfg_index,
	input  wire cfg_data_t  cfg_data
);

	cfg_t       cfg;
	stage_ctl_t ctl;

	// per-stage occupancy
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	zone_t x_zone_s4, y_zone_s4;

	jnzq_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// a stage can take new data when empty or when the stage ahead moves on
	assign rdy4 = !v_s4 || zone.ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign sample.ready = rdy1;

	// payload only loads when a valid request moves in
	assign ctl.load_s1 = rdy1 && sample.valid;
	assign ctl.load_s2 = rdy2 && v_s1;
	assign ctl.load_s3 = rdy3 && v_s2;
	assign ctl.load_s4 = rdy4 && v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= sample.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	jnzq_axis u_axis_x (
		.clk      (clk),
		.ctl      (ctl),
		.cfg      (cfg.x),
		.position (sample.x_position),
		.zone_s4  (x_zone_s4)
	);

	jnzq_axis u_axis_y (
		.clk      (clk),
		.ctl      (ctl),
		.cfg      (cfg.y),
		.position (sample.y_position),
		.zone_s4  (y_zone_s4)
	);

	// last stage doubles as the output register
	assign zone.valid  = v_s4;
	assign zone.x_zone = x_zone_s4;
	// y axis runs the other way: low readings give positive zones
	assign zone.y_zone = -y_zone_s4;

endmodule

`default_nettype wire

>>> rtl/jnzq_checker.sv
// jnzq_checker: port-level assertions for the quantizer top, attached by bind
// depends on jnzq_pkg and joystick_nine_zone_quantizer_top
`timescale 1ns / 1ps
`default_nettype none

module jnzq_checker import jnzq_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	input wire logic  s_valid,
	input wire logic  s_ready,
	input wire logic  z_valid,
	input wire logic  z_ready,
	input wire zone_t x_zone,
	input wire zone_t y_zone
);

	// a result waiting to be taken stays
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		z_valid && !z_ready |=> z_valid)
		else $error("result dropped while stalled");

	// stalled result keeps its value
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		z_valid && !z_ready |=> $stable(x_zone) && $stable(y_zone))
		else $error("result changed while stalled");

	// zones always within the nine levels
	a_zone_range: assert property (@(posedge clk) disable iff (!arst_n)
		z_valid |-> x_zone >= ZONE_NEG_4 && x_zone <= ZONE_POS_4
		         && y_zone >= ZONE_NEG_4 && y_zone <= ZONE_POS_4)
		else $error("zone out of range");

	// with the result side kept open, an accepted request comes out of the output stage
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_valid && s_ready) ##1 z_ready ##1 z_ready ##1 z_ready |=> z_valid)
		else $error("result missing after pipeline latency");

	// a free output stage always lets a request in
	a_ready_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!z_valid |-> s_ready)
		else $error("request refused with free output stage");

endmodule

bind joystick_nine_zone_quantizer_top jnzq_checker u_jnzq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_valid (sample.valid),
	.s_ready (sample.ready),
	.z_valid (zone.valid),
	.z_ready (zone.ready),
	.x_zone  (zone.x_zone),
	.y_zone  (zone.y_zone)
);

`default_nettype wire

>>> tb/joystick_nine_zone_quantizer_top_tb.sv
// joystick_nine_zone_quantizer_top_tb: self-checking bench for the nine-zone stick quantizer
// drives samples and calibration writes, predicts both zones per request and checks results
// depends on jnzq_pkg, jnzq_if and joystick_nine_zone_quantizer_top
`timescale 1ns / 1ps

module joystick_nine_zone_quantizer_top_tb;
	import jnzq_pkg::*;

	// clocking and run shape
	localparam int HALF_PERIOD     = 2;
	localparam int RESET_CYCLES    = 8;
	localparam int DRAIN_CYCLES    = 6;	// pipeline is four deep, a little slack on top
	localparam int NUM_PHASES      = 12;
	localparam int ITEMS_PER_PHASE = 160;
	localparam int IDLE_LIGHT      = 17;
	localparam int IDLE_HEAVY      = 49;
	localparam int MAX_REPORTS     = 50;
	localparam int POS_TOP         = (1 << POSITION_WIDTH) - 1;

	// index 7 has no register behind it, writes there must be dropped
	localparam cfg_index_t REG_UNUSED = 3'd7;

	// one axis worth of calibration
	typedef struct packed {
		position_t lo;
		position_t mid;
		position_t hi;
	} axis_cal_t;

	// full register set as the block should hold it
	typedef struct packed {
		axis_cal_t x;
		axis_cal_t y;
		bits_t     bits;
	} cal_set_t;

	typedef struct packed {
		zone_t x_zone;
		zone_t y_zone;
	} zone_pair_t;

	// directed row: when known is set the zones are typed in, else predicted
	typedef struct packed {
		position_t x;
		position_t y;
		logic      known;
		zone_t     x_zone;
		zone_t     y_zone;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	cfg_index_t cfg_index;
	cfg_data_t  cfg_data;

	jnzq_sample_if sample_ch ();
	jnzq_zone_if   zone_ch ();

	joystick_nine_zone_quantizer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.zone      (zone_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// shadow of the calibration registers, tracks every write
	cal_set_t cal_now;

	// zones still owed by the block, oldest first
	zone_pair_t pending_zones [$];

	int mismatch_count = 0;
	int send_idle_pct  = IDLE_LIGHT;
	int recv_idle_pct  = IDLE_HEAVY;

	// directed part, all at reset calibration: dead zone 8, centre band 120..136,
	// full low up to 8, full high from 247; inner split boundaries hit on both sides
	stim_row_t directed_rows [0:21] = '{
		'{8'd0,   8'd0,   1'b1, ZONE_NEG_4, ZONE_POS_4},
		'{8'd255, 8'd255, 1'b1, ZONE_POS_4, ZONE_NEG_4},
		'{8'd128, 8'd128, 1'b1, ZONE_0,     ZONE_0},
		'{8'd0,   8'd255, 1'b1, ZONE_NEG_4, ZONE_NEG_4},
		'{8'd255, 8'd0,   1'b1, ZONE_POS_4, ZONE_POS_4},
		'{8'd120, 8'd136, 1'b1, ZONE_0,     ZONE_0},
		'{8'd136, 8'd120, 1'b1, ZONE_0,     ZONE_0},
		'{8'd8,   8'd247, 1'b1, ZONE_NEG_4, ZONE_NEG_4},
		'{8'd247, 8'd8,   1'b1, ZONE_POS_4, ZONE_POS_4},
		'{8'd119, 8'd137, 1'b0, ZONE_0,     ZONE_0},
		'{8'd9,   8'd246, 1'b0, ZONE_0,     ZONE_0},
		'{8'd45,  8'd46,  1'b0, ZONE_0,     ZONE_0},
		'{8'd82,  8'd83,  1'b0, ZONE_0,     ZONE_0},
		'{8'd172, 8'd173, 1'b0, ZONE_0,     ZONE_0},
		'{8'd209, 8'd210, 1'b0, ZONE_0,     ZONE_0},
		'{8'd1,   8'd254, 1'b0, ZONE_0,     ZONE_0},
		'{8'd127, 8'd129, 1'b0, ZONE_0,     ZONE_0},
		'{8'd170, 8'd85,  1'b0, ZONE_0,     ZONE_0},
		'{8'd85,  8'd170, 1'b0, ZONE_0,     ZONE_0},
		'{8'd64,  8'd192, 1'b0, ZONE_0,     ZONE_0},
		'{8'd33,  8'd224, 1'b0, ZONE_0,     ZONE_0},
		'{8'd100, 8'd150, 1'b0, ZONE_0,     ZONE_0}
	};

	// first phases after the directed part: resolution outside 1..8, reversed and
	// collapsed calibration, both dead zone widths at the 6/7 boundary
	cal_set_t fixed_cals [0:4] = '{
		'{'{8'd0,   8'd128, 8'd255}, '{8'd0,   8'd128, 8'd255}, 4'd0},
		'{'{8'd255, 8'd128, 8'd0},   '{8'd0,   8'd0,   8'd0},   4'd15},
		'{'{8'd0,   8'd0,   8'd255}, '{8'd255, 8'd255, 8'd255}, 4'd6},
		'{'{8'd0,   8'd255, 8'd255}, '{8'd0,   8'd1,   8'd2},   4'd7},
		'{'{8'd10,  8'd128, 8'd246}, '{8'd100, 8'd110, 8'd120}, 4'd1}
	};

	task automatic report_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
	endtask

	// zone on the x orientation: negative toward minimum, positive toward maximum
	function automatic zone_t axis_zone(position_t pos, axis_cal_t a, int dead);
		int p, mn, mid, mx, band_lo, band_hi, span, third, widen;
		p   = int'(pos);
		mn  = int'(a.lo);
		mid = int'(a.mid);
		mx  = int'(a.hi);
		// centre band wins over everything, then the full-travel ends
		if (p >= mid - dead && p <= mid + dead) return ZONE_0;
		if (p <= mn + dead) return ZONE_NEG_4;
		if (p >= mx - dead) return ZONE_POS_4;
		if (p < mid - dead) begin
			band_lo = mn + dead + 1;
			band_hi = mid - dead - 1;
		end else begin
			band_lo = mid + dead + 1;
			band_hi = mx - dead - 1;
		end
		// sv int division truncates toward zero, so a negative span behaves as required
		span  = band_hi - band_lo + 1;
		third = span / 3;
		widen = (span - third * 3 == 2) ? 1 : 0;
		if (p < mid - dead) begin
			if (p <= band_hi - third - third - widen) return ZONE_NEG_3;
			if (p >= band_hi - third + 1) return ZONE_NEG_1;
			return ZONE_NEG_2;
		end
		if (p <= band_lo + third - 1) return ZONE_POS_1;
		if (p >= band_lo + third + third + widen) return ZONE_POS_3;
		return ZONE_POS_2;
	endfunction

	function automatic zone_pair_t quantize_sample(position_t x, position_t y);
		int         dead;
		zone_pair_t z;
		dead     = (cal_now.bits < BITS_FINE_LIMIT) ? int'(DEAD_NARROW) : int'(DEAD_WIDE);
		z.x_zone = axis_zone(x, cal_now.x, dead);
		// y runs the other way round: low readings come out positive
		z.y_zone = zone_t'(-int'(axis_zone(y, cal_now.y, dead)));
		return z;
	endfunction

	function automatic position_t clamp_position(int p);
		if (p < 0) p = 0;
		if (p > POS_TOP) p = POS_TOP;
		return position_t'(p);
	endfunction

	// mostly near the calibration points so band edges and splits get hit often
	function automatic position_t pick_position(axis_cal_t a);
		int p;
		case ($urandom_range(0, 4))
			0: p = int'($urandom_range(0, POS_TOP));
			1: p = int'(a.mid) + int'($urandom_range(0, 24)) - 12;
			2: p = int'(a.lo) + int'($urandom_range(0, 24)) - 12;
			3: p = int'(a.hi) + int'($urandom_range(0, 24)) - 12;
			default: p = int'($urandom_range(a.hi, a.lo));
		endcase
		return clamp_position(p);
	endfunction

	function automatic axis_cal_t random_axis();
		position_t v0, v1, v2, t;
		axis_cal_t a;
		v0 = position_t'($urandom_range(0, POS_TOP));
		v1 = position_t'($urandom_range(0, POS_TOP));
		v2 = position_t'($urandom_range(0, POS_TOP));
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				// well ordered stick, the usual case
				if (v0 > v1) begin t = v0; v0 = v1; v1 = t; end
				if (v1 > v2) begin t = v1; v1 = v2; v2 = t; end
				if (v0 > v1) begin t = v0; v0 = v1; v1 = t; end
				a = '{v0, v1, v2};
			end
			5: begin
				// points squeezed together, spans go small or negative
				a.mid = v1;
				a.lo  = clamp_position(int'(v1) - int'($urandom_range(0, 20)));
				a.hi  = clamp_position(int'(v1) + int'($urandom_range(0, 20)));
			end
			6, 7: a = '{v0, v1, v2};
			8: begin
				a.lo  = $urandom_range(0, 1) ? POS_MAX_RESET : POS_MIN_RESET;
				a.mid = $urandom_range(0, 1) ? POS_MAX_RESET : POS_MIN_RESET;
				a.hi  = $urandom_range(0, 1) ? POS_MAX_RESET : POS_MIN_RESET;
			end
			default: a = '{POS_MIN_RESET, POS_CENTRE_RESET, POS_MAX_RESET};
		endcase
		return a;
	endfunction

	function automatic cal_set_t random_calibration();
		cal_set_t s;
		s.x    = random_axis();
		s.y    = random_axis();
		s.bits = bits_t'($urandom_range(0, (1 << BITS_WIDTH) - 1));
		return s;
	endfunction

	task automatic write_reg(cfg_index_t idx, cfg_data_t data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_X_MINIMUM:   cal_now.x.lo  = position_t'(data);
			REG_X_CENTRE:    cal_now.x.mid = position_t'(data);
			REG_X_MAXIMUM:   cal_now.x.hi  = position_t'(data);
			REG_Y_MINIMUM:   cal_now.y.lo  = position_t'(data);
			REG_Y_CENTRE:    cal_now.y.mid = position_t'(data);
			REG_Y_MAXIMUM:   cal_now.y.hi  = position_t'(data);
			REG_SAMPLE_BITS: cal_now.bits  = bits_t'(data);
			default: ;
		endcase
	endtask

	task automatic program_calibration(cal_set_t s);
		write_reg(REG_X_MINIMUM, cfg_data_t'(s.x.lo));
		write_reg(REG_X_CENTRE, cfg_data_t'(s.x.mid));
		write_reg(REG_X_MAXIMUM, cfg_data_t'(s.x.hi));
		write_reg(REG_Y_MINIMUM, cfg_data_t'(s.y.lo));
		write_reg(REG_Y_CENTRE, cfg_data_t'(s.y.mid));
		write_reg(REG_Y_MAXIMUM, cfg_data_t'(s.y.hi));
		write_reg(REG_SAMPLE_BITS, cfg_data_t'(s.bits));
		// a stray write after the real ones must not alias onto any register
		if ($urandom_range(0, 1)) begin
			write_reg(REG_UNUSED, cfg_data_t'($urandom));
		end
		cfg_we <= 1'b0;
	endtask

	// present one request, optionally after a random gap; valid stays up on return
	// so back-to-back requests never drop it for a step
	task automatic send_sample(position_t x, position_t y, logic known,
			zone_t x_zone, zone_t y_zone);
		zone_pair_t want;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid      <= 1'b1;
		sample_ch.x_position <= x;
		sample_ch.y_position <= y;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		if (known) begin
			want = '{x_zone, y_zone};
		end else begin
			want = quantize_sample(x, y);
		end
		pending_zones.push_back(want);
	endtask

	// stop sending and let every owed result come out before touching registers
	task automatic drain_pipeline();
		sample_ch.valid <= 1'b0;
		while (pending_zones.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// result side: accept at the edge, compare with the oldest owed pair, then
	// pick ready for the next cycle
	initial begin : zone_monitor
		zone_pair_t want;
		zone_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && zone_ch.valid && zone_ch.ready) begin
				if (pending_zones.size() == 0) begin
					report_mismatch($sformatf("result x=%0d y=%0d with nothing owed",
						zone_ch.x_zone, zone_ch.y_zone));
				end else begin
					want = pending_zones.pop_front();
					if (zone_ch.x_zone !== want.x_zone) begin
						report_mismatch($sformatf("x_zone got %0d want %0d",
							zone_ch.x_zone, want.x_zone));
					end
					if (zone_ch.y_zone !== want.y_zone) begin
						report_mismatch($sformatf("y_zone got %0d want %0d",
							zone_ch.y_zone, want.y_zone));
					end
				end
			end
			zone_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// main sequence: reset, directed table, then calibration phases of random requests
	initial begin : stimulus
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_index            <= REG_X_MINIMUM;
		cfg_data             <= '0;
		sample_ch.valid      <= 1'b0;
		sample_ch.x_position <= '0;
		sample_ch.y_position <= '0;
		cal_now = '{'{POS_MIN_RESET, POS_CENTRE_RESET, POS_MAX_RESET},
			'{POS_MIN_RESET, POS_CENTRE_RESET, POS_MAX_RESET}, BITS_RESET};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows run with reset calibration, first idle mix
		foreach (directed_rows[i]) begin
			send_sample(directed_rows[i].x, directed_rows[i].y, directed_rows[i].known,
				directed_rows[i].x_zone, directed_rows[i].y_zone);
		end

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			drain_pipeline();
			if (phase < $size(fixed_cals)) begin
				program_calibration(fixed_cals[phase]);
			end else begin
				program_calibration(random_calibration());
			end
			// light sender gaps with heavy result stalls, then swapped, then none
			if (phase < NUM_PHASES / 3) begin
				send_idle_pct = IDLE_LIGHT;
				recv_idle_pct = IDLE_HEAVY;
			end else if (phase < 2 * NUM_PHASES / 3) begin
				send_idle_pct = IDLE_HEAVY;
				recv_idle_pct = IDLE_LIGHT;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			repeat (ITEMS_PER_PHASE) begin
				send_sample(pick_position(cal_now.x), pick_position(cal_now.y), 1'b0,
					ZONE_0, ZONE_0);
			end
		end

		// tail: anything arriving while draining or after it shows up as unowed
		drain_pipeline();
		if (mismatch_count == 0) begin
			$display("joystick_nine_zone_quantizer_top verification clean");
		end else begin
			$display("joystick_nine_zone_quantizer_top verification failed");
		end
		$finish;
	end

	// hard stop far beyond the slowest legal run
	initial begin : run_limit
		#1_000_000;
		$display("joystick_nine_zone_quantizer_top verification failed");
		$finish;
	end

endmodule

>>> joystick_nine_zone_quantizer_top.f
rtl/jnzq_pkg.sv
rtl/jnzq_if.sv
rtl/jnzq_regs.sv
rtl/jnzq_axis.sv
rtl/joystick_nine_zone_quantizer_top.sv
rtl/jnzq_checker.sv
tb/joystick_nine_zone_quantizer_top_tb.sv
